/* hw/rtl/qcss_pkg.sv */
package qcss_pkg;

  // Field widths
  localparam int DIR_W    = 2;
  localparam int LEG_W    = 2;
  localparam int ANGLE_W  = 14;
  localparam int SPEED_W  = 12;
  localparam int PAUSE_W  = 15;
  localparam int STANCE_W = 13;
  localparam int AMP_W    = 11;
  localparam int DUR_W    = 16;
  localparam int IDX_W    = 3;   // command index within one request, 0..7

  // APB
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int QUEUE_DEPTH = 2;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;

  // Leg codes
  localparam logic [LEG_W-1:0] LEG_FR = 2'd0;
  localparam logic [LEG_W-1:0] LEG_FL = 2'd1;
  localparam logic [LEG_W-1:0] LEG_BR = 2'd2;
  localparam logic [LEG_W-1:0] LEG_BL = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_STANCE_FR = 3'd0;
  localparam logic [2:0] REG_STANCE_FL = 3'd1;
  localparam logic [2:0] REG_STANCE_BR = 3'd2;
  localparam logic [2:0] REG_STANCE_BL = 3'd3;
  localparam logic [2:0] REG_AMP       = 3'd4;
  localparam logic [2:0] REG_SPEED     = 3'd5;
  localparam logic [2:0] REG_DUR       = 3'd6;

  // Reset values
  localparam logic [STANCE_W-1:0] STANCE_RST = 13'd2880;
  localparam logic [AMP_W-1:0]    AMP_RST    = 11'd320;
  localparam logic [SPEED_W-1:0]  SPEED_RST  = 12'd1000;
  localparam logic [DUR_W-1:0]    DUR_RST    = 16'd600;

  // Reciprocals: x/10 = (x*52429)>>19 for x < 2^15, x/3 = (x*43691)>>17 for x < 2^16
  localparam logic [15:0] RECIP_10 = 16'd52429;
  localparam int          SHIFT_10 = 19;
  localparam logic [16:0] RECIP_3  = 17'd43691;
  localparam int          SHIFT_3  = 17;

  localparam logic signed [ANGLE_W:0] ANGLE_MAX = 15'sd8191;
  localparam logic signed [ANGLE_W:0] ANGLE_MIN = -15'sd8192;

  // One queued step request
  typedef struct packed {
    logic             walk;   // 0: stop request
    logic             fwd;
    logic [LEG_W-1:0] phase;  // position of the swing leg in the gait order
  } cmd_t;

  // Live configuration plus derived offsets and pause
  typedef struct packed {
    logic [3:0][STANCE_W-1:0] stance;
    logic [AMP_W-1:0]         amp;
    logic [SPEED_W-1:0]       speed;
    logic [AMP_W-1:0]         off3;
    logic [AMP_W-1:0]         off4;
    logic [PAUSE_W-1:0]       pause;
  } cfg_t;

  // Gait order: FL, BR, FR, BL
  function automatic logic [LEG_W-1:0] leg_order(input logic [LEG_W-1:0] pos);
    logic [LEG_W-1:0] leg;
    unique case (pos)
      2'd0:    leg = LEG_FL;
      2'd1:    leg = LEG_BR;
      2'd2:    leg = LEG_FR;
      default: leg = LEG_BL;
    endcase
    return leg;
  endfunction

endpackage

/* hw/rtl/qcss_if.sv */
interface qcss_in_if;
  logic                           valid;
  logic                           ready;
  logic [qcss_pkg::DIR_W-1:0]     direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

interface qcss_out_if;
  logic                                valid;
  logic                                ready;
  logic [qcss_pkg::LEG_W-1:0]          leg;
  logic signed [qcss_pkg::ANGLE_W-1:0] angle;
  logic [qcss_pkg::SPEED_W-1:0]        speed;
  logic [qcss_pkg::PAUSE_W-1:0]        pause_ms;
  logic                                last;

  modport source (output valid, output leg, output angle, output speed,
                  output pause_ms, output last, input ready);
  modport sink   (input valid, input leg, input angle, input speed,
                  input pause_ms, input last, output ready);
endinterface

/* hw/rtl/qcss_cfg.sv */
module qcss_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [qcss_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [qcss_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [qcss_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output qcss_pkg::cfg_t                cfg
);

  logic [3:0][qcss_pkg::STANCE_W-1:0] stance_r;
  logic [qcss_pkg::AMP_W-1:0]         amp_r;
  logic [qcss_pkg::SPEED_W-1:0]       speed_r;
  logic [qcss_pkg::DUR_W-1:0]         dur_r;
  logic [qcss_pkg::AMP_W-1:0]         off3_r, off3_nxt;
  logic [qcss_pkg::AMP_W-1:0]         off4_r, off4_nxt;
  logic [qcss_pkg::PAUSE_W-1:0]       pause_r, pause_nxt;

  logic        wr_en;
  logic [2:0]  reg_idx;
  logic [12:0] amp3, amp4;
  logic [28:0] prod3, prod4;
  logic [32:0] prod_dur;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stance_r <= {4{qcss_pkg::STANCE_RST}};
      amp_r    <= qcss_pkg::AMP_RST;
      speed_r  <= qcss_pkg::SPEED_RST;
      dur_r    <= qcss_pkg::DUR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        qcss_pkg::REG_STANCE_FR: stance_r[0] <= cfg_pwdata[qcss_pkg::STANCE_W-1:0];
        qcss_pkg::REG_STANCE_FL: stance_r[1] <= cfg_pwdata[qcss_pkg::STANCE_W-1:0];
        qcss_pkg::REG_STANCE_BR: stance_r[2] <= cfg_pwdata[qcss_pkg::STANCE_W-1:0];
        qcss_pkg::REG_STANCE_BL: stance_r[3] <= cfg_pwdata[qcss_pkg::STANCE_W-1:0];
        qcss_pkg::REG_AMP:       amp_r       <= cfg_pwdata[qcss_pkg::AMP_W-1:0];
        qcss_pkg::REG_SPEED:     speed_r     <= cfg_pwdata[qcss_pkg::SPEED_W-1:0];
        qcss_pkg::REG_DUR:       dur_r       <= cfg_pwdata[qcss_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived offsets and pause: constant multiplies, registered
  always_comb begin
    amp3      = {1'b0, amp_r, 1'b0} + {2'b00, amp_r};
    amp4      = {amp_r, 2'b00};
    prod3     = {16'd0, amp3} * {13'd0, qcss_pkg::RECIP_10};
    prod4     = {16'd0, amp4} * {13'd0, qcss_pkg::RECIP_10};
    prod_dur  = {17'd0, dur_r} * {16'd0, qcss_pkg::RECIP_3};
    off3_nxt  = {1'b0, prod3[qcss_pkg::SHIFT_10 +: 10]};
    off4_nxt  = {1'b0, prod4[qcss_pkg::SHIFT_10 +: 10]};
    pause_nxt = prod_dur[qcss_pkg::SHIFT_3 +: qcss_pkg::PAUSE_W];
  end

  always_ff @(posedge clk) begin
    off3_r  <= off3_nxt;
    off4_r  <= off4_nxt;
    pause_r <= pause_nxt;
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      qcss_pkg::REG_STANCE_FR: cfg_prdata = {19'd0, stance_r[0]};
      qcss_pkg::REG_STANCE_FL: cfg_prdata = {19'd0, stance_r[1]};
      qcss_pkg::REG_STANCE_BR: cfg_prdata = {19'd0, stance_r[2]};
      qcss_pkg::REG_STANCE_BL: cfg_prdata = {19'd0, stance_r[3]};
      qcss_pkg::REG_AMP:       cfg_prdata = {21'd0, amp_r};
      qcss_pkg::REG_SPEED:     cfg_prdata = {20'd0, speed_r};
      qcss_pkg::REG_DUR:       cfg_prdata = {16'd0, dur_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.stance = stance_r;
    cfg.amp    = amp_r;
    cfg.speed  = speed_r;
    cfg.off3   = off3_r;
    cfg.off4   = off4_r;
    cfg.pause  = pause_r;
  end

endmodule

/* hw/rtl/qcss_front.sv */
module qcss_front (
  input  logic           clk,
  input  logic           rst_n,
  qcss_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           q_push,
  output qcss_pkg::cmd_t q_entry
);

  logic [qcss_pkg::LEG_W-1:0] phase_r, phase_nxt;
  logic                       accept;

  assign in_ch.ready = ~q_full;
  assign accept      = in_ch.valid & ~q_full;
  assign q_push      = accept;

  // Classify; phase snapshot travels with the word
  always_comb begin
    q_entry.walk  = (in_ch.direction != qcss_pkg::DIR_STOP);
    q_entry.fwd   = (in_ch.direction == qcss_pkg::DIR_FWD);
    q_entry.phase = phase_r;
    phase_nxt     = (accept && q_entry.walk) ? phase_r + 2'd1 : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

/* hw/rtl/qcss_fifo.sv */
module qcss_fifo #(
  parameter int DEPTH = qcss_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qcss_pkg::cmd_t wr_entry,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output qcss_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qcss_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

/* hw/rtl/qcss_back.sv */
module qcss_back (
  input  logic           clk,
  input  logic           rst_n,
  input  qcss_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  qcss_pkg::cmd_t head,
  output logic           pop,
  qcss_out_if.source     out_ch
);

  localparam int AW = qcss_pkg::ANGLE_W;

  logic [qcss_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [qcss_pkg::LEG_W-1:0]   leg_r, leg_nxt;
  logic signed [AW-1:0]         angle_r, angle_nxt;
  logic [qcss_pkg::SPEED_W-1:0] speed_r;
  logic [qcss_pkg::PAUSE_W-1:0] pause_r, pause_nxt;
  logic                         last_r, last_cmd;

  logic                          advance;
  logic [qcss_pkg::LEG_W-1:0]    pos, sub;
  logic                          is_swing, right, add;
  logic [qcss_pkg::AMP_W-1:0]    off;
  logic [qcss_pkg::STANCE_W-1:0] stance;
  logic signed [AW:0]            st_s, off_s, sum;

  assign advance = head_valid & (~out_valid_r | out_ch.ready);
  assign last_cmd = head.walk ? (idx_r == 3'd7) : (idx_r == 3'd3);
  assign pop     = advance & last_cmd;

  always_comb begin
    sub = idx_r[qcss_pkg::LEG_W-1:0];
    // indexes 0..2 step over the swing leg, 3 is the swing, 4..7 all legs
    if (!idx_r[2] && idx_r != 3'd3) begin
      pos = (sub < head.phase) ? sub : sub + 2'd1;
    end else if (idx_r == 3'd3) begin
      pos = head.phase;
    end else begin
      pos = sub;
    end
    leg_nxt  = head.walk ? qcss_pkg::leg_order(pos) : sub;
    is_swing = head.walk & (pos == head.phase) & (idx_r >= 3'd3);
    if (!head.walk) begin
      off = '0;
    end else if (is_swing) begin
      off = cfg.amp;
    end else if (idx_r < 3'd3) begin
      off = cfg.off3;
    end else begin
      off = cfg.off4;
    end
    right  = (leg_nxt == qcss_pkg::LEG_FR) | (leg_nxt == qcss_pkg::LEG_BR);
    add    = (right == head.fwd) ^ is_swing;
    stance = cfg.stance[leg_nxt];
    st_s   = $signed({2'b00, stance});
    off_s  = $signed({4'b0000, off});
    sum    = add ? st_s + off_s : st_s - off_s;
    if (sum > qcss_pkg::ANGLE_MAX) begin
      angle_nxt = qcss_pkg::ANGLE_MAX[AW-1:0];
    end else if (sum < qcss_pkg::ANGLE_MIN) begin
      angle_nxt = qcss_pkg::ANGLE_MIN[AW-1:0];
    end else begin
      angle_nxt = sum[AW-1:0];
    end
    pause_nxt = (head.walk && (idx_r == 3'd2 || idx_r == 3'd3 || idx_r == 3'd7))
                ? cfg.pause : '0;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (advance) begin
      idx_nxt = idx_r + 3'd1;
    end
    out_valid_nxt = advance | (out_valid_r & ~out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      leg_r   <= leg_nxt;
      angle_r <= angle_nxt;
      speed_r <= cfg.speed;
      pause_r <= pause_nxt;
      last_r  <= last_cmd;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.leg      = leg_r;
  assign out_ch.angle    = angle_r;
  assign out_ch.speed    = speed_r;
  assign out_ch.pause_ms = pause_r;
  assign out_ch.last     = last_r;

endmodule

/* hw/rtl/quadruped_creep_step_sequencer.sv */
// Channel   Dir  Handshake        Payload
// in_ch     in   valid/ready      direction (0 stop, 1 fwd, 2/3 back)
// out_ch    out  valid/ready      leg, angle, speed, pause_ms, last
// cfg_*     in   APB, pready = 1  seven registers at byte address 4*i
//
// One output word per cycle while out_ch.ready is high; a walk request
// gives 8 words, a stop 4; the back end, one command a cycle, sets that rate.
// Input words are taken while the request queue has room, also while a
// result is still held in the output register. The first word passes the
// queue, then the output register. Synchronous active-low reset clears phase,
// queue and output valid; configuration returns to its reset values.
module quadruped_creep_step_sequencer #(
  parameter int QUEUE_DEPTH = qcss_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  qcss_in_if.sink                     in_ch,
  qcss_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [qcss_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [qcss_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [qcss_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  qcss_pkg::cfg_t cfg;
  qcss_pkg::cmd_t q_entry, q_head;
  logic           q_push, q_full, q_pop, q_head_valid;

  // Register file; offsets and pause derived in the cycle after a write takes effect
  qcss_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // Front: classifies the request, stamps and advances the gait phase
  qcss_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  // Short request queue between front and back
  qcss_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_entry  (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  // Back: walks the head request one command per unstalled cycle into the output register
  qcss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .head_valid(q_head_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

endmodule

/* hw/rtl/qcss_checker.sv */
module qcss_checker #(
  parameter int QUEUE_DEPTH = qcss_pkg::QUEUE_DEPTH
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [qcss_pkg::LEG_W-1:0]         out_leg,
  input logic signed [qcss_pkg::ANGLE_W-1:0] out_angle,
  input logic                               out_last
);

  localparam int OUT_W = $clog2(QUEUE_DEPTH + 2);

  // Requests accepted whose final word has not yet been taken
  logic [OUT_W-1:0] pend_r, pend_nxt;
  logic             in_acc, out_done;

  assign in_acc   = in_valid & in_ready;
  assign out_done = out_valid & out_ready & out_last;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_done) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_done && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_leg) && $stable(out_angle)
                                && $stable(out_last))
    else $error("output word changed while stalled");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("output word with no request pending");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= OUT_W'(QUEUE_DEPTH + 1))
    else $error("more requests pending than queue and output can hold");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> pend_r >= OUT_W'(QUEUE_DEPTH))
    else $error("input stalled with room in the queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind quadruped_creep_step_sequencer qcss_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_qcss_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_leg  (out_ch.leg),
  .out_angle(out_ch.angle),
  .out_last (out_ch.last)
);

/* tb/quadruped_creep_step_sequencer_tb.sv */
`timescale 1ns / 100ps

// Creep-gait step sequencer bench.
// Step requests go in over in_ch, and servo command words come back over out_ch.
// A behavioural gait model, kept in step with every register write, queues
// the command words that each accepted request should produce. A checker
// then compares every word leaving the block with the oldest queued one.
module quadruped_creep_step_sequencer_tb;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 16;   // idle cycles after the last word

  // Swing-leg order by gait phase, phase 0 in the low bits: FL, BR, FR, BL.
  localparam logic [3:0][qcss_pkg::LEG_W-1:0] GAIT_ORDER =
    {qcss_pkg::LEG_BL, qcss_pkg::LEG_FR, qcss_pkg::LEG_BR, qcss_pkg::LEG_FL};

  typedef struct {
    logic [qcss_pkg::LEG_W-1:0]          leg;
    logic signed [qcss_pkg::ANGLE_W-1:0] angle;
    logic [qcss_pkg::SPEED_W-1:0]        speed;
    logic [qcss_pkg::PAUSE_W-1:0]        pause_ms;
    logic                                last;
  } servo_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  qcss_in_if  in_ch ();
  qcss_out_if out_ch ();

  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [qcss_pkg::ADDR_W-1:0] cfg_paddr;
  logic [qcss_pkg::DATA_W-1:0] cfg_pwdata;
  logic [qcss_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;

  quadruped_creep_step_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Gait model state: a mirror of the block's registers and its phase.
  logic [qcss_pkg::STANCE_W-1:0] stance_cfg [4];
  logic [qcss_pkg::AMP_W-1:0]    amp_cfg;
  logic [qcss_pkg::SPEED_W-1:0]  speed_cfg;
  logic [qcss_pkg::DUR_W-1:0]    dur_cfg;
  logic [1:0]                    gait_pos;

  servo_cmd_t pending_cmds [$];
  int fail_count   = 0;
  int cycle_count  = 0;
  int send_idle_pct  = 0;   // chance (%) of an idle cycle before each request
  int recv_stall_pct = 0;   // chance (%) of holding ready low in a cycle
  int hold_cycles    = 0;   // long receiver hold-off, counted down below

  // ---------------------------------------------------------------------------
  // Gait model
  // ---------------------------------------------------------------------------

  function automatic int leg_stance(input logic [qcss_pkg::LEG_W-1:0] leg);
    return int'(stance_cfg[leg]);
  endfunction

  // Right legs take +off when add_right is set, left legs the opposite sign.
  function automatic int offset_angle(input logic [qcss_pkg::LEG_W-1:0] leg,
                                      input int off, input logic add_right);
    logic add;
    add = (leg == qcss_pkg::LEG_FR || leg == qcss_pkg::LEG_BR) ? add_right : !add_right;
    return add ? leg_stance(leg) + off : leg_stance(leg) - off;
  endfunction

  function automatic void queue_cmd(input logic [qcss_pkg::LEG_W-1:0] leg,
                                    input int angle, input int pause, input logic last);
    servo_cmd_t c;
    // saturate to the 14-bit signed angle range
    if (angle > 8191)  angle = 8191;
    if (angle < -8192) angle = -8192;
    c.leg      = leg;
    c.angle    = angle[qcss_pkg::ANGLE_W-1:0];
    c.speed    = speed_cfg;
    c.pause_ms = pause[qcss_pkg::PAUSE_W-1:0];
    c.last     = last;
    pending_cmds.push_back(c);
  endfunction

  // Queue the command words for one accepted request and advance the phase.
  function automatic void predict_commands(input logic [qcss_pkg::DIR_W-1:0] dir);
    logic                       fwd;
    logic [qcss_pkg::LEG_W-1:0] swing;
    logic [qcss_pkg::LEG_W-1:0] leg;
    int amp, off3, off4, pause, swing_tgt, n;
    if (dir == qcss_pkg::DIR_STOP) begin
      // all legs to stance, phase held
      for (int i = 0; i < 4; i++) begin
        leg = qcss_pkg::LEG_W'(i);
        queue_cmd(leg, leg_stance(leg), 0, i == 3);
      end
      return;
    end
    fwd   = (dir == qcss_pkg::DIR_FWD);   // code 3 walks backward like code 2
    swing = GAIT_ORDER[gait_pos];
    amp   = int'(amp_cfg);
    off3  = (amp * 3) / 10;
    off4  = (amp * 4) / 10;
    pause = int'(dur_cfg) / 3;
    n     = 0;
    // weight shift on the three supporting legs
    for (int i = 0; i < 4; i++) begin
      leg = GAIT_ORDER[i];
      if (leg != swing) begin
        n++;
        queue_cmd(leg, offset_angle(leg, off3, fwd), (n == 3) ? pause : 0, 1'b0);
      end
    end
    // swing leg, opposite sign to its supporting rule
    swing_tgt = offset_angle(swing, amp, !fwd);
    queue_cmd(swing, swing_tgt, pause, 1'b0);
    // settle: every leg, swing leg holds its swing angle
    for (int i = 0; i < 4; i++) begin
      leg = GAIT_ORDER[i];
      queue_cmd(leg, (leg == swing) ? swing_tgt : offset_angle(leg, off4, fwd),
                (i == 3) ? pause : 0, i == 3);
    end
    gait_pos = gait_pos + 2'd1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: every accepted command word against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_commands
    servo_cmd_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected command word: leg %0d angle %0d", out_ch.leg, out_ch.angle);
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.leg !== want.leg) begin
          $error("leg: expected %0d, got %0d", want.leg, out_ch.leg);
          fail_count++;
        end
        if (out_ch.angle !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, out_ch.angle);
          fail_count++;
        end
        if (out_ch.speed !== want.speed) begin
          $error("speed: expected %0d, got %0d", want.speed, out_ch.speed);
          fail_count++;
        end
        if (out_ch.pause_ms !== want.pause_ms) begin
          $error("pause_ms: expected %0d, got %0d", want.pause_ms, out_ch.pause_ms);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  = hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quadruped_creep_step_sequencer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request word; valid stays high into the next call unless it idles.
  task automatic send_request(input logic [qcss_pkg::DIR_W-1:0] dir);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.direction <= dir;
    do @(posedge clk); while (!in_ch.ready);
    predict_commands(dir);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every predicted word has come out, then let the pipe settle.
  task automatic wait_drained();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write then read-back of one register; updates the gait model too.
  task automatic write_reg(input logic [2:0] idx,
                           input logic [qcss_pkg::DATA_W-1:0] value);
    logic [qcss_pkg::DATA_W-1:0] stored;
    stored = '0;
    case (idx)
      qcss_pkg::REG_STANCE_FR, qcss_pkg::REG_STANCE_FL,
      qcss_pkg::REG_STANCE_BR, qcss_pkg::REG_STANCE_BL: begin
        stance_cfg[idx[1:0]] = value[qcss_pkg::STANCE_W-1:0];
        stored[qcss_pkg::STANCE_W-1:0] = value[qcss_pkg::STANCE_W-1:0];
      end
      qcss_pkg::REG_AMP: begin
        amp_cfg = value[qcss_pkg::AMP_W-1:0];
        stored[qcss_pkg::AMP_W-1:0] = value[qcss_pkg::AMP_W-1:0];
      end
      qcss_pkg::REG_SPEED: begin
        speed_cfg = value[qcss_pkg::SPEED_W-1:0];
        stored[qcss_pkg::SPEED_W-1:0] = value[qcss_pkg::SPEED_W-1:0];
      end
      qcss_pkg::REG_DUR: begin
        dur_cfg = value[qcss_pkg::DUR_W-1:0];
        stored[qcss_pkg::DUR_W-1:0] = value[qcss_pkg::DUR_W-1:0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    // back-to-back read setup straight after the write access
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== stored) begin
      $error("prdata: expected %0d, got %0d", stored, cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_all_regs(input int st_fr, input int st_fl, input int st_br,
                                input int st_bl, input int amp, input int spd,
                                input int dur);
    write_reg(qcss_pkg::REG_STANCE_FR, st_fr);
    write_reg(qcss_pkg::REG_STANCE_FL, st_fl);
    write_reg(qcss_pkg::REG_STANCE_BR, st_br);
    write_reg(qcss_pkg::REG_STANCE_BL, st_bl);
    write_reg(qcss_pkg::REG_AMP, amp);
    write_reg(qcss_pkg::REG_SPEED, spd);
    write_reg(qcss_pkg::REG_DUR, dur);
  endtask

  function automatic logic [qcss_pkg::DIR_W-1:0] random_direction();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return qcss_pkg::DIR_STOP;
    if (roll < 22) return 2'd3;
    if (roll < 62) return qcss_pkg::DIR_FWD;
    return 2'd2;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: every phase both ways, stops between walks hold the phase,
  // direction code 3 walks backward.
  task automatic test_reset_gait();
    send_request(qcss_pkg::DIR_STOP);
    repeat (4) send_request(qcss_pkg::DIR_FWD);
    send_request(qcss_pkg::DIR_STOP);
    send_request(qcss_pkg::DIR_FWD);
    send_request(qcss_pkg::DIR_STOP);
    repeat (3) send_request(2'd2);
    repeat (4) send_request(2'd3);
    stop_sending();
    wait_drained();
  endtask

  // Register extremes: top amplitude, speed and duration with zero stance, then all zero.
  task automatic test_config_extremes();
    write_all_regs(0, 0, 0, 0, 2047, 4095, 65535);
    repeat (4) send_request(qcss_pkg::DIR_FWD);
    send_request(2'd2);
    send_request(qcss_pkg::DIR_STOP);
    stop_sending();
    wait_drained();
    write_all_regs(0, 0, 0, 0, 0, 0, 0);
    send_request(qcss_pkg::DIR_FWD);
    send_request(2'd2);
    send_request(qcss_pkg::DIR_STOP);
    stop_sending();
    wait_drained();
  endtask

  // Stance at the top of the register so that angles clip at +8191.
  task automatic test_angle_saturation();
    write_all_regs(8191, 8191, 8191, 8191, 2047, 1234, 1);
    repeat (4) send_request(qcss_pkg::DIR_FWD);
    repeat (4) send_request(2'd2);
    send_request(qcss_pkg::DIR_STOP);
    stop_sending();
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // request queue fills and in_ch.ready drops.
  task automatic test_output_backpressure();
    write_all_regs(2880, 2880, 2880, 2880, 320, 1000, 600);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 200;
    repeat (20) send_request(random_direction());
    stop_sending();
    wait_drained();
  endtask

  // Random traffic, idling in alternate stretches, with a fresh random configuration.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count);
    write_all_regs($urandom_range(5760), $urandom_range(5760), $urandom_range(5760),
                   $urandom_range(5760), $urandom_range(1440), $urandom_range(4095),
                   $urandom);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // odd stretches with no idling at all
      if (i % 40 == 20) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (i % 40 == 0) begin
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
      end
      send_request(random_direction());
    end
    stop_sending();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.direction = qcss_pkg::DIR_STOP;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    for (int i = 0; i < 4; i++) stance_cfg[i] = qcss_pkg::STANCE_RST;
    amp_cfg   = qcss_pkg::AMP_RST;
    speed_cfg = qcss_pkg::SPEED_RST;
    dur_cfg   = qcss_pkg::DUR_RST;
    gait_pos  = 2'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_gait();
    test_config_extremes();
    test_angle_saturation();
    test_output_backpressure();
    test_random_traffic(0, 0, 95);
    test_random_traffic(80, 0, 95);
    test_random_traffic(0, 80, 95);
    test_random_traffic(37, 37, 95);

    if (fail_count == 0) begin
      $display("quadruped_creep_step_sequencer: match");
    end else begin
      $display("quadruped_creep_step_sequencer: mismatch");
    end
    $finish;
  end

endmodule
